### rtl/core/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU replacement list package
// Shared types, codes and default sizes for the LRU replacement list.
// ----------------------------------------------------------------------------
package lru_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 16;
  localparam int FIELD_KEY_BITS = 16;
  localparam int OCC_BITS       = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_VICTIM = 2'd1,
    KIND_ERASE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [FIELD_KEY_BITS-1:0] key;
  } lru_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [FIELD_KEY_BITS-1:0] victim_key;
    logic [OCC_BITS-1:0]       occupancy;
  } lru_result_t;

endpackage

### rtl/core/lru_if.sv
// ----------------------------------------------------------------------------
// LRU replacement list channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lru_req_if;
  import lru_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [FIELD_KEY_BITS-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink (input valid, input kind, input key, output ready);
endinterface

interface lru_rsp_if;
  import lru_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [FIELD_KEY_BITS-1:0] victim_key;
  logic [OCC_BITS-1:0]       occupancy;

  modport source (output valid, output status, output victim_key, output occupancy,
                  input ready);
  modport sink (input valid, input status, input victim_key, input occupancy,
                output ready);
endinterface

### rtl/core/lru_list.sv
// ----------------------------------------------------------------------------
// LRU recency list
// Holds the keys in recency order and applies one request per cycle while
// advance is high, using a parallel key compare and a conditional one-place shift.
// ----------------------------------------------------------------------------
module lru_list #(
  parameter int CAPACITY = lru_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = lru_pkg::DEF_KEY_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  lru_pkg::lru_req_t    req,
  output lru_pkg::lru_result_t result
);
  import lru_pkg::*;

  localparam int STORE_BITS = (KEY_BITS < FIELD_KEY_BITS) ? KEY_BITS : FIELD_KEY_BITS;
  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);

  logic [STORE_BITS-1:0] keys      [CAPACITY];
  logic [STORE_BITS-1:0] keys_next [CAPACITY];
  logic [STORE_BITS-1:0] shift_dn  [CAPACITY];
  logic [STORE_BITS-1:0] shift_up  [CAPACITY];
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [CNT_BITS-1:0]   count_dec;
  logic [CAPACITY-1:0]   match;
  logic [IDX_BITS-1:0]   pos;
  logic [STORE_BITS-1:0] key_in;
  logic                  hit;
  logic                  full;
  logic                  empty;

  assign key_in    = req.key[STORE_BITS-1:0];
  assign full      = (count == CNT_BITS'(CAPACITY));
  assign empty     = (count == '0);
  assign count_dec = count - CNT_BITS'(1);

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNT_BITS'(i) < count) && (keys[i] == key_in);
      if (match[i]) begin
        pos = pos | IDX_BITS'(i);
      end
    end
    hit = |match;
  end

  always_comb begin
    shift_dn[0] = key_in;
    for (int i = 1; i < CAPACITY; i++) begin
      shift_dn[i] = keys[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      shift_up[i] = keys[i+1];
    end
    shift_up[CAPACITY-1] = keys[CAPACITY-1];
  end

  always_comb begin
    keys_next         = keys;
    count_next        = count;
    result.status     = STATUS_DONE;
    result.victim_key = '0;
    unique case (req.kind)
      KIND_INSERT: begin
        if (hit) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (IDX_BITS'(i) <= pos) begin
              keys_next[i] = shift_dn[i];
            end
          end
        end else if (full) begin
          result.status = STATUS_FULL;
        end else begin
          keys_next  = shift_dn;
          count_next = count + CNT_BITS'(1);
        end
      end
      KIND_VICTIM: begin
        if (empty) begin
          result.status = STATUS_MISS;
        end else begin
          result.victim_key = FIELD_KEY_BITS'(keys[count_dec[IDX_BITS-1:0]]);
          count_next        = count_dec;
        end
      end
      KIND_ERASE: begin
        if (hit) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (IDX_BITS'(i) >= pos) begin
              keys_next[i] = shift_up[i];
            end
          end
          count_next = count_dec;
        end else begin
          result.status = STATUS_MISS;
        end
      end
      default: begin
      end
    endcase
    result.occupancy = OCC_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keys <= keys_next;
    end
  end

endmodule

### rtl/core/lru_replacer_core.sv
// ----------------------------------------------------------------------------
// LRU replacement list core
// Recency-ordered key set with insert, victim and erase requests.
// A request is held in the request register, and its result in the response
// register. Throughput: one request per cycle unless the response channel
// stalls; the key compare and shift lie between the two registers.
// Reset: synchronous; the set comes out of reset empty, keys are not cleared.
// ----------------------------------------------------------------------------
module lru_replacer_core #(
  parameter int CAPACITY = lru_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = lru_pkg::DEF_KEY_BITS
) (
  input logic      clk,
  input logic      rst,
  lru_req_if.sink  req,
  lru_rsp_if.source rsp
);
  import lru_pkg::*;

  lru_req_t    req_q;
  logic        req_valid;
  lru_result_t result;
  lru_result_t rsp_q;
  logic        rsp_valid;
  logic        advance;

  assign advance   = req_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req.ready) begin
      req_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.kind <= req.kind;
      req_q.key  <= req.key;
    end
  end

  lru_list #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_list (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req_q),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= result;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_q.status;
  assign rsp.victim_key = rsp_q.victim_key;
  assign rsp.occupancy  = rsp_q.occupancy;

endmodule
